### design/wpt_pkg.sv
// wpt_pkg: shared constants, status and opcode codes, beat and command types
// for the websocket payload tracker; no dependencies
package wpt_pkg;

    // frame limits
    localparam logic [31:0] CONTROL_MAX = 32'd125;
    localparam logic [3:0]  READ_BYTES  = 4'd8;

    // control buffer organization: eight byte lanes, one row per chunk
    localparam int BUF_BYTES   = 128;
    localparam int CHUNK_BYTES = 8;
    localparam int BUF_ROWS    = BUF_BYTES / CHUNK_BYTES;
    localparam int ROW_W       = $clog2(BUF_ROWS);
    localparam int LANE_W      = $clog2(CHUNK_BYTES);
    localparam int BUF_ADDR_W  = $clog2(BUF_BYTES);

    // result status codes
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DATA    = 3'd1;
    localparam logic [2:0] ST_CONTROL = 3'd2;
    localparam logic [2:0] ST_PARTIAL = 3'd3;
    localparam logic [2:0] ST_DROPPED = 3'd4;
    localparam logic [2:0] ST_FAIL    = 3'd5;

    // frame opcodes
    localparam logic [3:0] OP_CONT   = 4'd0;
    localparam logic [3:0] OP_TEXT   = 4'd1;
    localparam logic [3:0] OP_BINARY = 4'd2;
    localparam logic [3:0] OP_CLOSE  = 4'd8;
    localparam logic [3:0] OP_PING   = 4'd9;
    localparam logic [3:0] OP_PONG   = 4'd10;

    typedef struct packed {
        logic        hdr_valid;
        logic [3:0]  opcode;
        logic        fin;
        logic [31:0] length;
        logic [3:0]  count;
        logic [63:0] data;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  opcode;
        logic        fin;
        logic [31:0] length;
        logic [31:0] offset;
        logic [3:0]  count;
        logic [63:0] bytes;
        logic        last;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic load_item;
        logic load_chunk;
        logic chunk_inc;
        logic frame_clr;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic ctrl_done;
        logic chunk_last;
    } t_sts;

    function automatic logic f_is_data(input logic [3:0] op);
        return (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BINARY);
    endfunction

    function automatic logic f_is_ctrl(input logic [3:0] op);
        return (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
    endfunction

    // zero every byte at or above n
    function automatic logic [63:0] f_keep_bytes(input logic [63:0] v, input logic [3:0] n);
        logic [63:0] r;
        r = '0;
        for (int j = 0; j < CHUNK_BYTES; j++) begin
            if (4'(j) < n) begin
                r[8*j +: 8] = v[8*j +: 8];
            end
        end
        return r;
    endfunction

endpackage

### design/wpt_in_if.sv
// wpt_in_if: input channel of the payload tracker, valid/ready plus one read
// no dependencies
interface wpt_in_if;
    logic        valid;
    logic        ready;
    logic        hdr_valid;
    logic [3:0]  frame_opcode_in;
    logic        fin_flag;
    logic [31:0] payload_length;
    logic [3:0]  nbytes;
    logic [63:0] data_bytes;

    modport source (output valid, hdr_valid, frame_opcode_in, fin_flag, payload_length,
                    nbytes, data_bytes, input ready);
    modport sink (input valid, hdr_valid, frame_opcode_in, fin_flag, payload_length,
                  nbytes, data_bytes, output ready);
endinterface

### design/wpt_out_if.sv
// wpt_out_if: result channel of the payload tracker, valid/ready plus one chunk
// no dependencies
interface wpt_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [3:0]  out_opcode;
    logic        out_fin;
    logic [31:0] out_length;
    logic [31:0] out_offset;
    logic [3:0]  out_count;
    logic [63:0] out_bytes;
    logic        last;

    modport source (output valid, status, out_opcode, out_fin, out_length, out_offset,
                    out_count, out_bytes, last, input ready);
    modport sink (input valid, status, out_opcode, out_fin, out_length, out_offset,
                  out_count, out_bytes, last, output ready);
endinterface

### design/wpt_ram.sv
// wpt_ram: generic single write port ram with registered read
// depends on wpt_pkg for default sizes
module wpt_ram
    import wpt_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = BUF_ROWS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### design/wpt_datapath.sv
// wpt_datapath: frame tracking registers, read classification, control byte
// buffer lanes and result register; depends on wpt_pkg and wpt_ram
module wpt_datapath
    import wpt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    input  t_cmd    i_cmd,
    output t_sts    o_sts,
    output t_result o_res,
    output logic    o_res_valid,
    input  logic    i_res_ready
);
    // held frame
    logic        r_active;
    logic        r_dropping;
    logic [3:0]  r_held_op;
    logic        r_held_fin;
    logic [31:0] r_held_len;
    logic [31:0] r_rcount;
    logic [ROW_W-1:0] r_chunk;

    // result register
    t_result r_out;
    logic    r_out_valid;

    // effective frame for this read
    logic [3:0]  h_op;
    logic        h_fin;
    logic [31:0] h_len;
    logic [31:0] h_rc;
    logic        h_drop;
    logic        drop_new;
    logic        mismatch;
    logic        cnt_bad;
    logic [31:0] remain;
    logic [31:0] cnt32;
    logic        overrun;
    logic        done;
    logic [31:0] new_rc;
    logic [63:0] kept;

    t_result n_item_res;
    logic    upd_store;
    logic    upd_clear;
    logic    ctrl_wr;
    logic    ctrl_done;

    t_result     chunk_res;
    logic [BUF_ADDR_W-1:0] chunk_off;
    logic [BUF_ADDR_W-1:0] chunk_rem;
    logic [3:0]  chunk_n;
    logic        chunk_last;
    logic [63:0] lane_word;
    logic [7:0]  w_lane_rd [CHUNK_BYTES];

    assign cnt32    = {28'd0, i_item.count};
    assign cnt_bad  = i_item.count > READ_BYTES;
    assign h_op     = r_active ? r_held_op  : i_item.opcode;
    assign h_fin    = r_active ? r_held_fin : i_item.fin;
    assign h_len    = r_active ? r_held_len : i_item.length;
    assign h_rc     = r_active ? r_rcount   : 32'd0;
    assign drop_new = (!f_is_ctrl(i_item.opcode) && !f_is_data(i_item.opcode)) ||
                      (f_is_ctrl(i_item.opcode) &&
                       (!i_item.fin || i_item.length > CONTROL_MAX));
    assign h_drop   = r_active ? r_dropping : drop_new;
    assign mismatch = r_active && ((r_held_op != i_item.opcode) ||
                                   (r_held_fin != i_item.fin) ||
                                   (r_held_len != i_item.length));
    assign remain   = h_len - h_rc;
    assign overrun  = cnt32 > remain;
    assign done     = cnt32 == remain;
    assign new_rc   = h_rc + cnt32;
    assign kept     = f_keep_bytes(i_item.data, i_item.count);

    // classify the read
    always_comb begin
        n_item_res      = '0;
        n_item_res.last = 1'b1;
        upd_store       = 1'b0;
        upd_clear       = 1'b0;
        ctrl_wr         = 1'b0;
        ctrl_done       = 1'b0;
        if (!i_item.hdr_valid) begin
            n_item_res.status = (i_item.count == 4'd0) ? ST_IDLE : ST_FAIL;
        end else if (cnt_bad || mismatch || overrun) begin
            n_item_res.status = ST_FAIL;
            upd_clear         = 1'b1;
        end else if (f_is_data(h_op)) begin
            if (h_len == 32'd0) begin
                upd_clear = 1'b1;
                if (h_op == OP_BINARY && h_fin) begin
                    n_item_res.status = ST_DATA;
                    n_item_res.opcode = OP_BINARY;
                    n_item_res.fin    = 1'b1;
                end else begin
                    n_item_res.status = ST_DROPPED;
                end
            end else if (i_item.count == 4'd0) begin
                n_item_res.status = ST_IDLE;
                upd_store         = 1'b1;
            end else begin
                n_item_res.status = ST_DATA;
                n_item_res.opcode = h_op;
                n_item_res.fin    = h_fin;
                n_item_res.length = h_len;
                n_item_res.offset = h_rc;
                n_item_res.count  = i_item.count;
                n_item_res.bytes  = kept;
                upd_clear         = done;
                upd_store         = !done;
            end
        end else if (h_drop) begin
            if (done) begin
                n_item_res.status = ST_DROPPED;
                upd_clear         = 1'b1;
            end else begin
                n_item_res.status = (i_item.count == 4'd0) ? ST_IDLE : ST_PARTIAL;
                upd_store         = 1'b1;
            end
        end else begin
            ctrl_wr   = 1'b1;
            upd_store = 1'b1;
            ctrl_done = done;
            n_item_res.status = (i_item.count == 4'd0) ? ST_IDLE : ST_PARTIAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_dropping <= 1'b0;
            r_held_op  <= OP_CONT;
            r_held_fin <= 1'b0;
            r_held_len <= '0;
            r_rcount   <= '0;
        end else if ((i_cmd.take && upd_clear) || i_cmd.frame_clr) begin
            r_active   <= 1'b0;
            r_dropping <= 1'b0;
            r_held_op  <= OP_CONT;
            r_held_fin <= 1'b0;
            r_held_len <= '0;
            r_rcount   <= '0;
        end else if (i_cmd.take && upd_store) begin
            r_active   <= 1'b1;
            r_dropping <= h_drop;
            r_held_op  <= h_op;
            r_held_fin <= h_fin;
            r_held_len <= h_len;
            r_rcount   <= new_rc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk <= '0;
        end else if (i_cmd.take) begin
            r_chunk <= '0;
        end else if (i_cmd.chunk_inc) begin
            r_chunk <= r_chunk + ROW_W'(1);
        end
    end

    // byte lanes: buffer byte at position p sits in lane p mod 8, row p / 8
    for (genvar L = 0; L < CHUNK_BYTES; L++) begin : g_lane
        logic [LANE_W-1:0]     i_lane;
        logic [BUF_ADDR_W-1:0] pos;
        logic                  we;
        logic [7:0]            wdata;

        assign i_lane = LANE_W'(L) - h_rc[LANE_W-1:0];
        assign pos    = h_rc[BUF_ADDR_W-1:0] + BUF_ADDR_W'(i_lane);
        assign we     = i_cmd.take && ctrl_wr && ({1'b0, i_lane} < i_item.count);
        assign wdata  = 8'(i_item.data >> {i_lane, 3'b000});

        wpt_ram #(
            .WIDTH (8),
            .DEPTH (BUF_ROWS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr (pos[BUF_ADDR_W-1:LANE_W]),
            .i_wdata (wdata),
            .i_raddr (r_chunk),
            .o_rdata (w_lane_rd[L])
        );
    end

    // chunk of the control run at row r_chunk
    assign chunk_off  = {r_chunk, {LANE_W{1'b0}}};
    assign chunk_rem  = r_held_len[BUF_ADDR_W-1:0] - chunk_off;
    assign chunk_last = chunk_rem <= BUF_ADDR_W'(CHUNK_BYTES);
    assign chunk_n    = chunk_last ? chunk_rem[3:0] : 4'(CHUNK_BYTES);

    always_comb begin
        lane_word = '0;
        for (int j = 0; j < CHUNK_BYTES; j++) begin
            lane_word[8*j +: 8] = w_lane_rd[j];
        end
        chunk_res        = '0;
        chunk_res.status = ST_CONTROL;
        chunk_res.opcode = r_held_op;
        chunk_res.fin    = r_held_fin;
        chunk_res.length = r_held_len;
        chunk_res.offset = {{(32-BUF_ADDR_W){1'b0}}, chunk_off};
        chunk_res.count  = chunk_n;
        chunk_res.bytes  = f_keep_bytes(lane_word, chunk_n);
        chunk_res.last   = chunk_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_item || i_cmd.load_chunk) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_out <= n_item_res;
        end else if (i_cmd.load_chunk) begin
            r_out <= chunk_res;
        end
    end

    assign o_res             = r_out;
    assign o_res_valid       = r_out_valid;
    assign o_sts.out_free    = !r_out_valid || i_res_ready;
    assign o_sts.ctrl_done   = ctrl_done;
    assign o_sts.chunk_last  = chunk_last;
endmodule

### design/wpt_ctrl.sv
// wpt_ctrl: controller state machine, takes reads and sequences control chunk runs
// depends on wpt_pkg
module wpt_ctrl
    import wpt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [1:0] S_RUN  = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_SEND = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_RUN: begin
                o_in_ready = i_sts.out_free;
                if (i_in_valid && i_sts.out_free) begin
                    o_cmd.take = 1'b1;
                    if (i_sts.ctrl_done) begin
                        n_state = S_READ;
                    end else begin
                        o_cmd.load_item = 1'b1;
                    end
                end
            end
            S_READ: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (i_sts.out_free) begin
                    o_cmd.load_chunk = 1'b1;
                    if (i_sts.chunk_last) begin
                        o_cmd.frame_clr = 1'b1;
                        n_state         = S_RUN;
                    end else begin
                        o_cmd.chunk_inc = 1'b1;
                        n_state         = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

### design/websocket_payload_tracker.sv
// websocket_payload_tracker: top level, joins controller and datapath to the
// input and result channels; depends on wpt_pkg, wpt_in_if, wpt_out_if,
// wpt_ctrl and wpt_datapath
//
// usage
//   i_item carries one payload read per beat: frame metadata from a parsed
//   header plus up to eight payload bytes. o_result carries result beats.
//   an ordinary read gives its single result in the output register in the
//   cycle after it is taken; one read per cycle is taken while the output
//   register is free and no chunk run is active. a read that completes a
//   valid control frame starts a chunk run of ceil(length / 8) beats (one
//   beat for an empty frame); each chunk is a registered byte lane read, then
//   an output register load, and i_item.ready stays low for the whole run.
//   last marks the final beat of each read's run.
//   reset clears the frame tracking and the output valid flag; the control
//   byte buffer is not cleared, each byte is written before it is read.
//   when the receiver stalls, the result beat holds in the output register
//   and i_item.ready drops until it is taken; nothing is lost or repeated.
module websocket_payload_tracker
    import wpt_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    wpt_in_if.sink    i_item,
    wpt_out_if.source o_result
);
    t_item   w_item;
    t_result w_res;
    t_cmd    w_cmd;
    t_sts    w_sts;
    logic    w_in_ready;
    logic    w_res_valid;

    // incoming beat into the datapath format
    assign w_item.hdr_valid = i_item.hdr_valid;
    assign w_item.opcode    = i_item.frame_opcode_in;
    assign w_item.fin       = i_item.fin_flag;
    assign w_item.length    = i_item.payload_length;
    assign w_item.count     = i_item.nbytes;
    assign w_item.data      = i_item.data_bytes;
    assign i_item.ready     = w_in_ready;

    // sequencing: take reads, run control chunks
    wpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // frame state, byte lanes and output register
    wpt_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_item),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_res       (w_res),
        .o_res_valid (w_res_valid),
        .i_res_ready (o_result.ready)
    );

    // result beat out
    assign o_result.valid      = w_res_valid;
    assign o_result.status     = w_res.status;
    assign o_result.out_opcode = w_res.opcode;
    assign o_result.out_fin    = w_res.fin;
    assign o_result.out_length = w_res.length;
    assign o_result.out_offset = w_res.offset;
    assign o_result.out_count  = w_res.count;
    assign o_result.out_bytes  = w_res.bytes;
    assign o_result.last       = w_res.last;

`ifndef ASSERT_OFF
    // a taken read that does not start a chunk run shows its result next cycle
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && w_in_ready && !w_sts.ctrl_done) |=> o_result.valid)
        else $error("taken read gave no result beat");

    // only control chunk runs span several beats
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.status != ST_CONTROL) |-> o_result.last)
        else $error("non-control result without last");

    // no chunk carries more than eight bytes
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.out_count <= 4'd8))
        else $error("result byte count out of range");
`endif
endmodule
